>>> rtl/sliding_window_mean_stddev_assert.svh
// Assertion macros used by sliding_window_mean_stddev. Each expands to one labeled concurrent
// assertion clocked on aclk and muted while aresetn is low.
`ifndef SLIDING_WINDOW_MEAN_STDDEV_ASSERT_SVH
`define SLIDING_WINDOW_MEAN_STDDEV_ASSERT_SVH

// Check that expr holds at every clock edge.
`define SWMS_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define SWMS_IMPLIES_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/swms_pkg.sv
`default_nettype none

package swms_pkg;

    // Width and reset value of the window length register.
    localparam int unsigned CFG_BITS = 5;
    localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd4;

    // Status of one bit-serial arithmetic unit.
    typedef struct packed {
        logic busy;     // stepping
        logic valid;    // result held since the last step
    } unit_stat_t;

endpackage

`default_nettype wire

>>> rtl/sliding_window_mean_stddev.sv
`default_nettype none

// Moving-window mean and standard deviation of signed Q4.12 samples.
// Each sample word taken on the s_ channel yields one result word on the m_
// channel: the mean of the window (truncated toward zero), the population
// standard deviation (floored) and the number of samples in the window.
// The window length is set through the cfg_ channel (0 acts as 1, values
// above WINDOW_MAX act as WINDOW_MAX); a write clears the window. Write it
// only while no sample is in flight. cfg_ready is always high; s_tready
// drops while cfg_valid is high, so a length write never meets a sample.
// One sample is in flight at a time; s_tready returns in the cycle after
// the result is loaded, so no new word is taken before the last result
// is loaded. The block runs its bit-serial units one after another:
// squares and the mean divider, the n*sumsq multiplier, the variance
// divider (2*SB-1 quotient bits) and the square root.
// The result sits in an output register: while the sink stalls, the next
// sample is accepted and computed, and holds in the last step until the
// register empties. Reset sets the window length to 4 and empties the window.
module sliding_window_mean_stddev #(
    parameter int WINDOW_MAX  = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // window length write
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [swms_pkg::CFG_BITS-1:0] cfg_data,
    // sample in; tdata: sample
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // result out; tdata: window_mean, window_stddev, fill_count
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [((2*SAMPLE_BITS+(($clog2(WINDOW_MAX+1) < 2) ? 2 :
                   $clog2(WINDOW_MAX+1))+7)/8)*8-1:0] m_tdata
);

    localparam int SB   = SAMPLE_BITS;
    localparam int NW   = ($clog2(WINDOW_MAX+1) < 2) ? 2 : $clog2(WINDOW_MAX+1);
    localparam int PW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SUMW = SB + NW;            // signed running sum
    localparam int SMW  = SB - 1 + NW;        // magnitude of the sum
    localparam int SQW  = 2*SB - 2 + NW;      // running sum of squares
    localparam int NUMW = SQW + NW;           // n*sumsq - sum^2
    localparam int VARW = 2*SB - 1;           // variance
    localparam int TDO  = ((2*SB + NW + 7)/8)*8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_PH1,
        S_PH2,
        S_PH3,
        S_PH4,
        S_DONE
    } state_t;

    state_t                      state_reg;

    logic [swms_pkg::CFG_BITS-1:0] window_len_reg;
    logic [NW-1:0]               eff_len;
    logic [NW-1:0]               held_count_reg;
    logic [PW-1:0]               ptr_reg;
    logic [NW-1:0]               ptr_ext;
    logic [PW-1:0]               ptr_next;
    logic [PW-1:0]               wr_addr;
    logic signed [SUMW-1:0]      sum_reg;
    logic signed [SUMW-1:0]      sum_next;
    logic [SQW-1:0]              sumsq_reg;
    logic [SQW-1:0]              sumsq_next;
    logic                        accept;
    logic                        cfg_we;
    logic                        full;
    logic                        full_reg;

    logic signed [SB-1:0]        ring [WINDOW_MAX];
    logic signed [SB-1:0]        s_sample;
    logic signed [SB-1:0]        x_reg;
    logic signed [SB-1:0]        old_q;
    logic signed [SB-1:0]        old_v;
    logic signed [SB:0]          pair_sum;
    logic signed [SB:0]          pair_diff;
    logic [SB:0]                 pair_sum_mag;
    logic [SB:0]                 pair_diff_mag;
    logic [SUMW-1:0]             sum_abs;
    logic [SMW-1:0]              sum_mag;
    logic [2*NW-1:0]             nsq_next;
    logic [2*NW-1:0]             nsq_reg;
    logic                        mean_neg_reg;
    logic                        delta_neg_reg;
    logic [NUMW-1:0]             num_next;
    logic [SB-1:0]               mean_out;
    logic [TDO-1:0]              m_tdata_next;
    logic [TDO-1:0]              m_tdata_reg;
    logic                        m_tvalid_reg;

    logic                        start_p1;
    logic                        start_p2;
    logic                        start_p3;
    logic                        start_p4;
    logic                        p1_done;

    logic [2*SB+1:0]             prod_d;
    logic [2*SMW-1:0]            prod_s;
    logic [NUMW-1:0]             prod_n;
    logic [SB-1:0]               q_m;
    logic [VARW-1:0]             q_v;
    logic [SB-1:0]               root;
    swms_pkg::unit_stat_t        stat_d;
    swms_pkg::unit_stat_t        stat_s;
    swms_pkg::unit_stat_t        stat_m;
    swms_pkg::unit_stat_t        stat_n;
    swms_pkg::unit_stat_t        stat_v;
    swms_pkg::unit_stat_t        stat_r;

    // Handshakes.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign s_sample  = s_tdata[SB-1:0];

    // Clamp the programmed length to 1..WINDOW_MAX.
    always_comb begin
        if (window_len_reg == '0) begin
            eff_len = NW'(1);
        end else if (int'(window_len_reg) > WINDOW_MAX) begin
            eff_len = NW'(WINDOW_MAX);
        end else begin
            eff_len = NW'(window_len_reg);
        end
    end

    // Append while filling, overwrite the oldest once full.
    assign full     = held_count_reg >= eff_len;
    assign ptr_ext  = NW'(ptr_reg);
    assign ptr_next = (ptr_ext + NW'(1) == eff_len) ? '0 : PW'(ptr_ext + NW'(1));
    assign wr_addr  = full ? ptr_reg : held_count_reg[PW-1:0];

    // Sample update: x - old and x + old drive the square delta, the new sum
    // drives the mean and sum^2.
    assign old_v         = full_reg ? old_q : '0;
    assign pair_sum      = (SB+1)'(x_reg) + (SB+1)'(old_v);
    assign pair_diff     = (SB+1)'(x_reg) - (SB+1)'(old_v);
    assign pair_sum_mag  = pair_sum[SB] ? '0 - pair_sum : pair_sum;
    assign pair_diff_mag = pair_diff[SB] ? '0 - pair_diff : pair_diff;
    assign sum_next      = sum_reg + SUMW'(x_reg) - SUMW'(old_v);
    assign sum_abs       = sum_next[SUMW-1] ? '0 - sum_next : sum_next;
    assign sum_mag       = sum_abs[SMW-1:0];
    assign nsq_next      = (2*NW)'(held_count_reg) * (2*NW)'(held_count_reg);

    // x^2 - old^2 = (x + old)(x - old), applied with its sign.
    assign sumsq_next = delta_neg_reg ? sumsq_reg - SQW'(prod_d)
                                      : sumsq_reg + SQW'(prod_d);
    assign num_next   = prod_n - prod_s;
    assign mean_out   = mean_neg_reg ? '0 - q_m : q_m;
    assign m_tdata_next = TDO'({held_count_reg, root, mean_out});

    assign start_p1 = (state_reg == S_PREP);
    assign p1_done  = stat_d.valid && stat_s.valid && stat_m.valid;
    assign start_p2 = (state_reg == S_PH1) && p1_done;
    assign start_p3 = (state_reg == S_PH2) && stat_n.valid;
    assign start_p4 = (state_reg == S_PH3) && stat_v.valid;

    // Sample ring: read the oldest entry and write the new one on accept.
    always_ff @(posedge aclk) begin
        if (accept) begin
            old_q         <= ring[ptr_reg];
            ring[wr_addr] <= s_sample;
        end
    end

    // Per-item operands.
    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg    <= s_sample;
            full_reg <= full;
        end
        if (start_p1) begin
            nsq_reg       <= nsq_next;
            mean_neg_reg  <= sum_next[SUMW-1];
            delta_neg_reg <= pair_sum[SB] ^ pair_diff[SB];
        end
    end

    // Sequencer, window state and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            window_len_reg <= swms_pkg::CFG_RESET;
            held_count_reg <= '0;
            ptr_reg        <= '0;
            sum_reg        <= '0;
            sumsq_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
        end else begin
            // Drop the word once taken; S_DONE reloads the register itself.
            if (m_tvalid_reg && m_tready && state_reg != S_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_we) begin
                // A length write empties the window.
                window_len_reg <= cfg_data;
                held_count_reg <= '0;
                ptr_reg        <= '0;
                sum_reg        <= '0;
                sumsq_reg      <= '0;
            end else begin
                unique case (state_reg)
                    S_IDLE: begin
                        if (accept) begin
                            if (full) begin
                                ptr_reg <= ptr_next;
                            end else begin
                                held_count_reg <= held_count_reg + NW'(1);
                            end
                            state_reg <= S_PREP;
                        end
                    end
                    S_PREP: begin
                        sum_reg   <= sum_next;
                        state_reg <= S_PH1;
                    end
                    S_PH1: begin
                        if (p1_done) begin
                            sumsq_reg <= sumsq_next;
                            state_reg <= S_PH2;
                        end
                    end
                    S_PH2: begin
                        if (stat_n.valid) begin
                            state_reg <= S_PH3;
                        end
                    end
                    S_PH3: begin
                        if (stat_v.valid) begin
                            state_reg <= S_PH4;
                        end
                    end
                    S_PH4: begin
                        if (stat_r.valid) begin
                            state_reg <= S_DONE;
                        end
                    end
                    S_DONE: begin
                        // Hold until the output register is free.
                        if (!m_tvalid_reg || m_tready) begin
                            m_tvalid_reg <= 1'b1;
                            m_tdata_reg  <= m_tdata_next;
                            state_reg    <= S_IDLE;
                        end
                    end
                    default: begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

    // Square delta: |x + old| * |x - old|.
    swms_ser_mul #(
        .AW(SB + 1),
        .BW(SB + 1)
    ) u_mul_delta (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_p1),
        .a        (pair_sum_mag),
        .b        (pair_diff_mag),
        .p        (prod_d),
        .stat     (stat_d)
    );

    // sum^2.
    swms_ser_mul #(
        .AW(SMW),
        .BW(SMW)
    ) u_mul_sum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_p1),
        .a        (sum_mag),
        .b        (sum_mag),
        .p        (prod_s),
        .stat     (stat_s)
    );

    // |sum| / n.
    swms_ser_div #(
        .DW(SMW),
        .VW(NW),
        .QW(SB)
    ) u_div_mean (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_p1),
        .dividend (sum_mag),
        .divisor  (held_count_reg),
        .quotient (q_m),
        .stat     (stat_m)
    );

    // n * sumsq.
    swms_ser_mul #(
        .AW(SQW),
        .BW(NW)
    ) u_mul_n (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_p2),
        .a        (sumsq_next),
        .b        (held_count_reg),
        .p        (prod_n),
        .stat     (stat_n)
    );

    // (n*sumsq - sum^2) / n^2.
    swms_ser_div #(
        .DW(NUMW),
        .VW(2*NW),
        .QW(VARW)
    ) u_div_var (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_p3),
        .dividend (num_next),
        .divisor  (nsq_reg),
        .quotient (q_v),
        .stat     (stat_v)
    );

    swms_ser_sqrt #(
        .RB(SB)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_p4),
        .radicand ({1'b0, q_v}),
        .root     (root),
        .stat     (stat_r)
    );

`include "sliding_window_mean_stddev_assert.svh"

    `SWMS_ALWAYS(a_fill_within_len, held_count_reg <= eff_len, "fill count above window length")
    `SWMS_ALWAYS(a_ptr_within_len, ptr_ext < eff_len, "oldest pointer outside the window")
    `SWMS_ALWAYS(a_unit_stat, !(stat_d.busy && stat_d.valid) && !(stat_v.busy && stat_v.valid), "unit busy and valid")
    `SWMS_IMPLIES_NEXT(a_accept_to_prep, s_tvalid && s_tready, state_reg == S_PREP, "sample did not start")

endmodule

`default_nettype wire

>>> rtl/swms_ser_mul.sv
`default_nettype none

// Shift-add multiplier: one bit of b per cycle, LSB first.
module swms_ser_mul #(
    parameter int AW = 16,
    parameter int BW = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [AW-1:0]        a,
    input  wire logic [BW-1:0]        b,
    output logic [AW+BW-1:0]          p,
    output swms_pkg::unit_stat_t      stat
);

    localparam int CW = $clog2(BW);

    logic              busy_reg;
    logic              valid_reg;
    logic [CW-1:0]     cnt_reg;
    logic [AW-1:0]     a_reg;
    logic [AW+BW-1:0]  p_reg;
    logic [AW+BW-1:0]  p_next;
    logic [AW:0]       acc_sum;

    assign acc_sum = {1'b0, p_reg[AW+BW-1:BW]} + (p_reg[0] ? {1'b0, a_reg} : '0);
    assign p_next  = {acc_sum, p_reg[BW-1:1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end else if (start) begin
            busy_reg  <= 1'b1;
            valid_reg <= 1'b0;
            cnt_reg   <= CW'(BW - 1);
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg  <= 1'b0;
                valid_reg <= 1'b1;
            end else begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= a;
            p_reg <= (AW+BW)'(b);
        end else if (busy_reg) begin
            p_reg <= p_next;
        end
    end

    assign p          = p_reg;
    assign stat.busy  = busy_reg;
    assign stat.valid = valid_reg;

endmodule

`default_nettype wire

>>> rtl/swms_ser_div.sv
`default_nettype none

// Restoring divider: one quotient bit per cycle. The caller
// guarantees dividend < divisor * 2**QW.
module swms_ser_div #(
    parameter int DW = 20,
    parameter int VW = 5,
    parameter int QW = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [DW-1:0]        dividend,
    input  wire logic [VW-1:0]        divisor,
    output logic [QW-1:0]             quotient,
    output swms_pkg::unit_stat_t      stat
);

    localparam int CW = $clog2(QW);

    logic              busy_reg;
    logic              valid_reg;
    logic [CW-1:0]     cnt_reg;
    logic [VW-1:0]     dv_reg;
    logic [VW+QW-1:0]  work_reg;
    logic [VW+QW-1:0]  work_next;
    logic [VW:0]       top;
    logic [VW:0]       diff;
    logic              ge;
    logic [VW-1:0]     rem_next;

    assign top       = work_reg[VW+QW-1:QW-1];
    assign ge        = top >= {1'b0, dv_reg};
    assign diff      = top - {1'b0, dv_reg};
    assign rem_next  = ge ? diff[VW-1:0] : top[VW-1:0];
    assign work_next = {rem_next, work_reg[QW-2:0], ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end else if (start) begin
            busy_reg  <= 1'b1;
            valid_reg <= 1'b0;
            cnt_reg   <= CW'(QW - 1);
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg  <= 1'b0;
                valid_reg <= 1'b1;
            end else begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dv_reg   <= divisor;
            work_reg <= (VW+QW)'(dividend);
        end else if (busy_reg) begin
            work_reg <= work_next;
        end
    end

    assign quotient   = work_reg[QW-1:0];
    assign stat.busy  = busy_reg;
    assign stat.valid = valid_reg;

endmodule

`default_nettype wire

>>> rtl/swms_ser_sqrt.sv
`default_nettype none

// Digit-by-digit integer square root: two radicand bits in, one root bit
// out per cycle.
module swms_ser_sqrt #(
    parameter int RB = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [2*RB-1:0]      radicand,
    output logic [RB-1:0]             root,
    output swms_pkg::unit_stat_t      stat
);

    localparam int CW = $clog2(RB);

    logic              busy_reg;
    logic              valid_reg;
    logic [CW-1:0]     cnt_reg;
    logic [2*RB-1:0]   rad_reg;
    logic [RB:0]       rem_reg;
    logic [RB-1:0]     root_reg;
    logic [RB+2:0]     rem_shift;
    logic [RB+2:0]     trial;
    logic              ge;
    logic [RB:0]       rem_next;

    assign rem_shift = {rem_reg, rad_reg[2*RB-1:2*RB-2]};
    assign trial     = (RB+3)'({root_reg, 2'b01});
    assign ge        = rem_shift >= trial;
    assign rem_next  = ge ? (RB+1)'(rem_shift - trial) : rem_shift[RB:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end else if (start) begin
            busy_reg  <= 1'b1;
            valid_reg <= 1'b0;
            cnt_reg   <= CW'(RB - 1);
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg  <= 1'b0;
                valid_reg <= 1'b1;
            end else begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[2*RB-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= {root_reg[RB-2:0], ge};
        end
    end

    assign root       = root_reg;
    assign stat.busy  = busy_reg;
    assign stat.valid = valid_reg;

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;

    // One result word as the block packs it: mean in the low bits, then the
    // standard deviation, then the fill count.
    typedef struct packed {
        logic [4:0]         fill;
        logic [15:0]        sd;
        logic signed [15:0] mean;
    } stats_word_t;

    localparam int RING_DEPTH  = 16;
    localparam int DRAIN_WAIT  = 100;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PHASE_ITEMS = 155;

    // Predicts the window statistics for every sample word taken and checks
    // the result words against them in order.
    class window_stats_board;
        logic signed [15:0] ring [RING_DEPTH];
        int unsigned        oldest;
        int unsigned        held;
        longint             sum_acc;
        longint unsigned    sq_acc;
        logic [4:0]         win_reg;
        stats_word_t        expected_stats[$];
        int                 errors;

        function new();
            errors  = 0;
            win_reg = 5'd4;
            clear();
        endfunction

        function void clear();
            foreach (ring[i]) ring[i] = '0;
            oldest  = 0;
            held    = 0;
            sum_acc = 0;
            sq_acc  = 0;
        endfunction

        function void set_window(logic [4:0] value);
            win_reg = value;
            clear();
        endfunction

        function int pending();
            return expected_stats.size();
        endfunction

        function longint unsigned int_sqrt(longint unsigned value);
            longint unsigned root;
            longint unsigned probe;
            root  = 0;
            probe = 64'd1 << 62;
            while (probe > value) probe = probe >> 2;
            while (probe != 0) begin
                if (value >= root + probe) begin
                    value = value - (root + probe);
                    root  = (root >> 1) + probe;
                end else begin
                    root = root >> 1;
                end
                probe = probe >> 2;
            end
            return root;
        endfunction

        function void take_sample(logic [15:0] raw);
            logic signed [15:0] x;
            longint             xv;
            longint             old_v;
            int unsigned        span;
            longint             n;
            longint unsigned    mag;
            longint unsigned    spread;
            stats_word_t        word;
            x  = raw;
            xv = longint'(x);
            // zero acts as one, anything past the ring depth saturates
            if (win_reg == 0) span = 1;
            else if (win_reg > RING_DEPTH) span = RING_DEPTH;
            else span = 32'(win_reg);
            if (held < span) begin
                ring[held] = x;
                held++;
            end else begin
                old_v   = longint'(ring[oldest]);
                sum_acc = sum_acc - old_v;
                sq_acc  = sq_acc - longint'(old_v * old_v);
                ring[oldest] = x;
                oldest  = (oldest + 1) % span;
            end
            sum_acc = sum_acc + xv;
            sq_acc  = sq_acc + longint'(xv * xv);
            n       = longint'(held);
            mag     = (sum_acc < 0) ? -sum_acc : sum_acc;
            spread  = (longint'(n) * sq_acc - mag * mag) / (n * n);
            word.mean = 16'(sum_acc / n);
            word.sd   = 16'(int_sqrt(spread));
            word.fill = 5'(held);
            expected_stats = {expected_stats, word};
        endfunction

        function void check_stats(logic signed [15:0] mean, logic [15:0] sd, logic [4:0] fill);
            stats_word_t want;
            if (expected_stats.size() == 0) begin
                $display("%0t: result word with no sample pending: mean %0d sd %0d fill %0d",
                         $time, mean, sd, fill);
                errors++;
                return;
            end
            want = expected_stats[0];
            expected_stats.delete(0);
            if (mean !== want.mean) begin
                $display("%0t: window_mean expected %0d actual %0d", $time, want.mean, mean);
                errors++;
            end
            if (sd !== want.sd) begin
                $display("%0t: window_stddev expected %0d actual %0d", $time, want.sd, sd);
                errors++;
            end
            if (fill !== want.fill) begin
                $display("%0t: fill_count expected %0d actual %0d", $time, want.fill, fill);
                errors++;
            end
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [swms_pkg::CFG_BITS-1:0] cfg_data;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [15:0]                   s_tdata;   // [15:0] sample
    logic                          m_tvalid;
    logic                          m_tready;
    logic [39:0]                   m_tdata;   // [15:0] window_mean, [31:16] window_stddev,
                                              // [36:32] fill_count, rest zero

    int unsigned sender_idle_pct;
    int unsigned sink_stall_pct;
    longint      cycles;

    window_stats_board stats = new();

    sliding_window_mean_stddev u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: check every word taken, then draw the sink's ready for the
    // next edge. Values read here are the ones from before the edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            stats.check_stats(m_tdata[15:0], m_tdata[31:16], m_tdata[36:32]);
        end
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Watchdog: fail the run if it has not finished by the cycle limit.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb NOT OK");
        $finish;
    end

    // Offer one sample word, with a random gap ahead of it while the sender
    // idles; hold it until the block takes it.
    task automatic send_sample(input logic [15:0] value);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        stats.take_sample(value);
    endtask

    // Drop valid and let every pending result word come out, then give the
    // block its latency again before anyone touches the window.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (stats.pending() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // Write the window length while the block is idle; this clears the window.
    task automatic write_window(input logic [4:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        stats.set_window(value);
        cfg_valid <= 1'b0;
    endtask

    // Full-range samples, with a heavy share of the rails, zero, minus
    // one and small values so the window sees both tiny and maximal spread.
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0, 1:    return 16'h8000;
            2, 3:    return 16'h7FFF;
            4:       return $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
            5:       return 16'($urandom_range(0, 31)) - 16'd16;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    logic [15:0] reset_run [10] = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF,
                                    16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h0001};
    logic [4:0]  phase_len [8]  = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd17, 5'd9, 5'd16};

    initial begin
        aclk            = 1'b0;
        aresetn         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        m_tready        = 1'b0;
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset length of four: fill with the negative rail (zero spread),
        // then slide the positive rail in, then minus one and one.
        foreach (reset_run[i]) send_sample(reset_run[i]);

        // A zero length acts as a window of one: spread stays zero.
        write_window(5'd0);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0005);
        send_sample(16'hFFFB);

        // Window of 16, half filled with alternating rails: largest deviation.
        write_window(5'd16);
        for (int i = 0; i < 8; i++) send_sample(i[0] ? 16'h7FFF : 16'h8000);

        // Random phases, cycling through the idling modes.
        for (int p = 0; p < 8; p++) begin
            write_window(phase_len[p]);
            case (p % 4)
                0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin sender_idle_pct = 71; sink_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  sink_stall_pct = 71; end
                default: begin sender_idle_pct = 26; sink_stall_pct = 26; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) send_sample(pick_sample());
        end

        drain();
        if (stats.errors == 0 && stats.pending() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
